// File: rtl/mmb_pkg.sv
// Shared types and address map constants for the mirrored memory map bus.
`default_nettype none
package mmb_pkg;

  // Request and response payloads.
  typedef struct packed {
    logic        op;
    logic [1:0]  access_size;
    logic [31:0] address;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        io_access;
    logic        fault;
  } rsp_t;

  // Access kind and size codes.
  localparam logic OP_WRITE = 1'b1;
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  // Decoded target of an access.
  typedef enum logic [3:0] {
    REG_CODE  = 4'd0,
    REG_MAIN  = 4'd1,
    REG_WORK  = 4'd2,
    REG_PAL   = 4'd3,
    REG_VID   = 4'd4,
    REG_OBJ   = 4'd5,
    REG_IO    = 4'd6,
    REG_OPEN  = 4'd7,
    REG_FAULT = 4'd8
  } region_e;

  // Width of a store length and of the running remainder.
  localparam int unsigned LEN_W = 25;

  // Address map.
  localparam logic [31:0] MAIN_BASE      = 32'h0200_0000;
  localparam logic [31:0] WORK_START     = 32'h0300_0000;
  localparam logic [31:0] WORK_BASE      = 32'h037F_8000;
  localparam logic [31:0] IO_START       = 32'h0400_0000;
  localparam logic [31:0] IO_END         = 32'h04FF_FFFF;
  localparam logic [31:0] PAL_BASE       = 32'h0500_0000;
  localparam logic [31:0] VID_BASE       = 32'h0600_0000;
  localparam logic [31:0] OBJ_BASE       = 32'h0700_0000;
  localparam logic [31:0] OPEN_BUS_START = 32'h0700_0800;

endpackage
`default_nettype wire

// File: rtl/mmb_ram.sv
// Byte-wide single-port memory with registered read data.
`default_nettype none
module mmb_ram #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [7:0]               wdata_i,
  output logic      [7:0]               rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // One access per cycle: write or read at the same address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/mirrored_memory_map_bus_top.sv
// Top level of the mirrored memory map bus: decode, offset unit, stores, result register.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o   | mmb_pkg::req_t
//   out     | output    | out_valid_o / out_ready_i | mmb_pkg::rsp_t
//
// An access to a store runs, for each byte, the reciprocal remainder unit (multiply, quotient
// and remainder steps) and then a memory step, plus a read data step for a read, between an
// accept step and a result step; I/O, open bus and faults go from the accept step to the result step.
// After reset a clearing pass writes zero to every byte of every store; no input is taken then.
// A result waits in its output register; a new access may be taken meanwhile, and the
// sequencer stalls in its result cycle while the output register is still full.
`default_nettype none
module mirrored_memory_map_bus_top #(
  parameter int unsigned CODE_RAM_BYTES = 32768,
  parameter int unsigned MAIN_BYTES     = 4194304,
  parameter int unsigned WORK_BYTES     = 262144,
  parameter int unsigned PALETTE_BYTES  = 2048,
  parameter int unsigned VIDEO_BYTES    = 671744,
  parameter int unsigned OBJECT_BYTES   = 2048
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire mmb_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output mmb_pkg::rsp_t      out_data_o
);
  import mmb_pkg::*;

  // Rounded-up reciprocal of a store length, scaled by two to the given shift.
  function automatic logic [32:0] recip_of_len(int unsigned len, int unsigned sh);
    logic [63:0] num;
    num = 64'd1 << sh;
    return 33'((num + 64'(len) - 64'd1) / 64'(len));
  endfunction

  localparam int unsigned NUM_STORES = 6;
  localparam int unsigned DEPTHS [NUM_STORES] = '{CODE_RAM_BYTES, MAIN_BYTES, WORK_BYTES,
                                                  PALETTE_BYTES, VIDEO_BYTES, OBJECT_BYTES};
  localparam int unsigned SHIFTS [NUM_STORES] = '{32 + $clog2(CODE_RAM_BYTES),
                                                  32 + $clog2(MAIN_BYTES),
                                                  32 + $clog2(WORK_BYTES),
                                                  32 + $clog2(PALETTE_BYTES),
                                                  32 + $clog2(VIDEO_BYTES),
                                                  32 + $clog2(OBJECT_BYTES)};
  localparam logic [32:0] RECIPS [NUM_STORES] = '{
    recip_of_len(CODE_RAM_BYTES, SHIFTS[0]), recip_of_len(MAIN_BYTES, SHIFTS[1]),
    recip_of_len(WORK_BYTES, SHIFTS[2]), recip_of_len(PALETTE_BYTES, SHIFTS[3]),
    recip_of_len(VIDEO_BYTES, SHIFTS[4]), recip_of_len(OBJECT_BYTES, SHIFTS[5])};
  localparam int unsigned MAX01 = (CODE_RAM_BYTES > MAIN_BYTES) ? CODE_RAM_BYTES : MAIN_BYTES;
  localparam int unsigned MAX23 = (WORK_BYTES > PALETTE_BYTES) ? WORK_BYTES : PALETTE_BYTES;
  localparam int unsigned MAX45 = (VIDEO_BYTES > OBJECT_BYTES) ? VIDEO_BYTES : OBJECT_BYTES;
  localparam int unsigned MAX03 = (MAX01 > MAX23) ? MAX01 : MAX23;
  localparam int unsigned MAX_DEPTH = (MAX03 > MAX45) ? MAX03 : MAX45;
  localparam int unsigned CLR_W = $clog2(MAX_DEPTH + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_QUO,
    S_REM,
    S_MEM,
    S_RD,
    S_FIN
  } state_e;

  state_e             state_q;
  logic [CLR_W-1:0]   clr_cnt_q;
  logic               op_q;
  logic [1:0]         last_q;
  logic [1:0]         bi_q;
  logic [31:0]        addr_q;
  logic [31:0]        wdata_q;
  region_e            region_q;
  logic               io_q;
  logic               fault_q;
  logic [31:0]        rdata_q;
  logic [31:0]        x_q;
  logic [LEN_W-1:0]   rem_q;
  logic [LEN_W-1:0]   len_q;
  logic [32:0]        mul_q;
  logic [5:0]         shf_q;
  logic [63:0]        prod_q;
  logic [31:0]        quo_q;
  logic               out_valid_q;
  rsp_t               out_data_q;

  region_e            dec_region;
  logic [32:0]        obj_end;
  logic [64:0]        quo_sum;
  logic [64:0]        quo_full;
  logic [31:0]        rem_full;
  logic [7:0]         rd_byte;
  logic [7:0]         ram_rd [NUM_STORES];

  // Base address of a store window.
  function automatic logic [31:0] base_of(region_e r);
    logic [31:0] b;
    b = '0;
    case (r)
      REG_MAIN: b = MAIN_BASE;
      REG_WORK: b = WORK_BASE;
      REG_PAL:  b = PAL_BASE;
      REG_VID:  b = VID_BASE;
      REG_OBJ:  b = OBJ_BASE;
      default:  b = '0;
    endcase
    return b;
  endfunction

  // Mirror length of a store.
  function automatic logic [LEN_W-1:0] len_of(region_e r);
    logic [LEN_W-1:0] l;
    l = LEN_W'(CODE_RAM_BYTES);
    case (r)
      REG_MAIN: l = LEN_W'(MAIN_BYTES);
      REG_WORK: l = LEN_W'(WORK_BYTES);
      REG_PAL:  l = LEN_W'(PALETTE_BYTES);
      REG_VID:  l = LEN_W'(VIDEO_BYTES);
      REG_OBJ:  l = LEN_W'(OBJECT_BYTES);
      default:  l = LEN_W'(CODE_RAM_BYTES);
    endcase
    return l;
  endfunction

  // Reciprocal multiplier of a store length.
  function automatic logic [32:0] mul_of(region_e r);
    logic [32:0] m;
    m = RECIPS[0];
    case (r)
      REG_MAIN: m = RECIPS[1];
      REG_WORK: m = RECIPS[2];
      REG_PAL:  m = RECIPS[3];
      REG_VID:  m = RECIPS[4];
      REG_OBJ:  m = RECIPS[5];
      default:  m = RECIPS[0];
    endcase
    return m;
  endfunction

  // Quotient shift that goes with the reciprocal of a store length.
  function automatic logic [5:0] shf_of(region_e r);
    logic [5:0] s;
    s = 6'(SHIFTS[0]);
    case (r)
      REG_MAIN: s = 6'(SHIFTS[1]);
      REG_WORK: s = 6'(SHIFTS[2]);
      REG_PAL:  s = 6'(SHIFTS[3]);
      REG_VID:  s = 6'(SHIFTS[4]);
      REG_OBJ:  s = 6'(SHIFTS[5]);
      default:  s = 6'(SHIFTS[0]);
    endcase
    return s;
  endfunction

  // Address decode on the first byte; the object window checks the whole access.
  always_comb begin
    obj_end = {1'b0, in_data_i.address} - {1'b0, OBJ_BASE}
            + ((in_data_i.access_size == SIZE_BYTE) ? 33'd1 :
               (in_data_i.access_size == SIZE_HALF) ? 33'd2 : 33'd4);
    if (in_data_i.address < MAIN_BASE) begin
      dec_region = REG_CODE;
    end else if (in_data_i.address < WORK_START) begin
      dec_region = REG_MAIN;
    end else if (in_data_i.address < IO_START) begin
      dec_region = REG_WORK;
    end else if (in_data_i.address <= IO_END) begin
      dec_region = REG_IO;
    end else if (in_data_i.address < VID_BASE) begin
      dec_region = REG_PAL;
    end else if (in_data_i.address < OBJ_BASE) begin
      dec_region = REG_VID;
    end else if (obj_end <= 33'(OBJECT_BYTES)) begin
      dec_region = REG_OBJ;
    end else if (in_data_i.address >= OPEN_BUS_START) begin
      dec_region = REG_OPEN;
    end else begin
      dec_region = REG_FAULT;
    end
  end

  // Exact quotient from the reciprocal product, then the remainder from it.
  always_comb begin
    quo_sum  = {1'b0, prod_q} + (mul_q[32] ? {1'b0, x_q, 32'd0} : 65'd0);
    quo_full = quo_sum >> shf_q;
    rem_full = x_q - quo_q * {{(32-LEN_W){1'b0}}, len_q};
  end

  // Read data of the selected store.
  always_comb begin
    case (region_q)
      REG_CODE: rd_byte = ram_rd[0];
      REG_MAIN: rd_byte = ram_rd[1];
      REG_WORK: rd_byte = ram_rd[2];
      REG_PAL:  rd_byte = ram_rd[3];
      REG_VID:  rd_byte = ram_rd[4];
      REG_OBJ:  rd_byte = ram_rd[5];
      default:  rd_byte = '0;
    endcase
  end

  // Stores, each written with zero during the clearing pass.
  for (genvar k = 0; k < NUM_STORES; k++) begin : g_store
    localparam int unsigned D = DEPTHS[k];
    localparam int unsigned AW = $clog2(D);
    logic [AW-1:0] addr;
    logic          we;
    logic [7:0]    wd;

    always_comb begin
      if (state_q == S_CLEAR) begin
        addr = AW'(clr_cnt_q);
        we   = clr_cnt_q < CLR_W'(D);
        wd   = '0;
      end else begin
        addr = rem_q[AW-1:0];
        we   = (state_q == S_MEM) && (op_q == OP_WRITE) && (region_q == region_e'(k));
        wd   = wdata_q[8*bi_q +: 8];
      end
    end

    mmb_ram #(.DEPTH(D)) u_ram (
      .clk_i  (clk_i),
      .we_i   (we),
      .addr_i (addr),
      .wdata_i(wd),
      .rdata_o(ram_rd[k])
    );
  end

  // Sequencer, offset unit and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      bi_q        <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == CLR_W'(MAX_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            op_q     <= in_data_i.op;
            last_q   <= (in_data_i.access_size == SIZE_BYTE) ? 2'd0 :
                        (in_data_i.access_size == SIZE_HALF) ? 2'd1 : 2'd3;
            addr_q   <= in_data_i.address;
            wdata_q  <= in_data_i.write_data;
            region_q <= dec_region;
            io_q     <= (dec_region == REG_IO);
            fault_q  <= (dec_region == REG_FAULT);
            rdata_q  <= '0;
            bi_q     <= '0;
            x_q      <= in_data_i.address - base_of(dec_region);
            len_q    <= len_of(dec_region);
            mul_q    <= mul_of(dec_region);
            shf_q    <= shf_of(dec_region);
            rem_q    <= '0;
            if (dec_region == REG_IO || dec_region == REG_OPEN ||
                dec_region == REG_FAULT) begin
              state_q <= S_FIN;
            end else begin
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_q  <= x_q * mul_q[31:0];
          state_q <= S_QUO;
        end
        S_QUO: begin
          quo_q   <= quo_full[31:0];
          state_q <= S_REM;
        end
        S_REM: begin
          rem_q   <= rem_full[LEN_W-1:0];
          state_q <= S_MEM;
        end
        S_MEM, S_RD: begin
          if (state_q == S_MEM && op_q != OP_WRITE) begin
            state_q <= S_RD;
          end else begin
            if (state_q == S_RD) begin
              rdata_q[8*bi_q +: 8] <= rd_byte;
            end
            if (bi_q == last_q) begin
              state_q <= S_FIN;
            end else begin
              bi_q    <= bi_q + 1'b1;
              x_q     <= addr_q + 32'(bi_q) + 32'd1 - base_of(region_q);
              rem_q   <= '0;
              state_q <= S_MUL;
            end
          end
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q          <= 1'b1;
            out_data_q.read_data <= (op_q == OP_WRITE) ? 32'd0 : rdata_q;
            out_data_q.io_access <= io_q;
            out_data_q.fault     <= fault_q;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // No access is taken while the stores are being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_ready_o) else $error("input taken during clearing pass");

  // The store offset is inside the store when the memory is accessed.
  a_offset_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MEM) |-> (rem_q < len_q)) else $error("store offset out of range");

  // I/O and fault results never carry data and never both hold.
  a_flag_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.io_access || out_data_o.fault)) |->
    (out_data_o.read_data == 32'd0 && !(out_data_o.io_access && out_data_o.fault)))
    else $error("flagged result with data");

  // A finished result is never overwritten before its transfer.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(out_valid_o) && !$past(out_ready_i)) |-> $stable(out_data_o))
    else $error("pending result overwritten");

endmodule
`default_nettype wire
